// ===== design/vector3_arithmetic_unit_assert.svh =====
// Assertion macros for the vector arithmetic unit.
// Needs clk and arst_n in the scope of the including module.
`ifndef VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define V3_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a signal is low while reset is held.
`define V3_ASSERT_RST(lbl, sig, msg) \
	lbl: assert property (@(posedge clk) (!arst_n |=> !(sig))) else $error(msg);
`endif

// ===== design/v3au_pkg.sv =====
// Package for the vector arithmetic unit: payload structs, command codes, helpers.
// No dependencies.
`default_nettype none
package v3au_pkg;
	localparam int FracBitsDefault = 16;
	localparam int SqrtSteps = 33;
	localparam int DivBits = 64;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_SCALE = 4'd3,
		CMD_DIV = 4'd4, CMD_DOT = 4'd5, CMD_CROSS = 4'd6, CMD_MAG = 4'd7,
		CMD_NORM = 4'd8
	} cmd_t;

	typedef struct packed {
		logic [3:0] command;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by_comp;
		logic signed [31:0] bz;
		logic signed [31:0] scalar_k;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] scalar_result;
		logic overflow;
		logic divide_by_zero;
	} out_item_t;

	// saturate a wide value to 32 bits
	function automatic logic [32:0] sat32(input logic signed [69:0] v);
		logic [32:0] r;
		if (v > 70'sh7FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
		else if (v < -70'sh80000000) r = {1'b1, 32'h80000000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/v3au_sqrt.sv =====
// Pipelined rounded integer square root, one result bit per stage.
// Depends on v3au_pkg.
`default_nettype none
module v3au_sqrt (
	input wire logic clk,
	input wire logic adv,
	input wire logic [2*v3au_pkg::SqrtSteps-1:0] rad,
	output logic [v3au_pkg::SqrtSteps:0] root
);
	import v3au_pkg::*;
	localparam int N = SqrtSteps;
	localparam int RW = 2 * N;

	logic [RW-1:0] rem_s [0:N];
	logic [N-1:0] r_s [0:N];

	// stage 0: load radicand
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= rad;
			r_s[0] <= '0;
		end
	end

	// one restoring step per stage, MSB first
	for (genvar g = 0; g < N; g++) begin : g_step
		logic [RW+1:0] trial;
		logic [RW+1:0] part;
		always_comb begin
			part = {2'b0, rem_s[g]} >> (2 * (N - 1 - g));
			trial = {{(RW - N){1'b0}}, r_s[g], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (part >= trial) begin
					rem_s[g+1] <= rem_s[g] - RW'(trial << (2 * (N - 1 - g)));
					r_s[g+1] <= {r_s[g][N-2:0], 1'b1};
				end else begin
					rem_s[g+1] <= rem_s[g];
					r_s[g+1] <= {r_s[g][N-2:0], 1'b0};
				end
			end
		end
	end

	// round: remainder s - r*r exceeds r means round up
	assign root = {1'b0, r_s[N]} + (N+1)'({{(RW-N){1'b0}}, r_s[N]} < rem_s[N]);
endmodule
`default_nettype wire

// ===== design/v3au_div.sv =====
// Pipelined unsigned divider giving floor(num/den), one quotient bit per stage.
// Depends on v3au_pkg.
`default_nettype none
module v3au_div (
	input wire logic clk,
	input wire logic adv,
	input wire logic [v3au_pkg::DivBits-1:0] num,
	input wire logic [v3au_pkg::DivBits-1:0] den,
	output logic [v3au_pkg::DivBits-1:0] quo
);
	import v3au_pkg::*;
	localparam int N = DivBits;

	logic [N-1:0] q_s [0:N];
	logic [N:0] r_s [0:N];
	logic [N-1:0] n_s [0:N];
	logic [N-1:0] d_s [0:N];

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s[0] <= '0;
			r_s[0] <= '0;
			n_s[0] <= num;
			d_s[0] <= den;
		end
	end

	// restoring division step; final stage gives floor(num/den)
	for (genvar g = 0; g < N; g++) begin : g_step
		logic [N:0] t;
		assign t = {r_s[g][N-1:0], n_s[g][N-1-g]};
		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[g+1] <= n_s[g];
				d_s[g+1] <= d_s[g];
				if (t >= {1'b0, d_s[g]}) begin
					r_s[g+1] <= t - {1'b0, d_s[g]};
					q_s[g+1] <= {q_s[g][N-2:0], 1'b1};
				end else begin
					r_s[g+1] <= t;
					q_s[g+1] <= {q_s[g][N-2:0], 1'b0};
				end
			end
		end
	end
	assign quo = q_s[N];
endmodule
`default_nettype wire

// ===== design/vector3_arithmetic_unit.sv =====
// Top level of the vector arithmetic unit: multiply stage, square root and divide pipelines.
// Depends on v3au_pkg, v3au_sqrt, v3au_div and the assertion header.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_data  (in_item_t)
//  output  | out_valid | out_stall | out_data (out_item_t)
//
// One item enters per cycle unless the pipeline is frozen. Stages: 2 for inputs and
// products, 34 across the square root, 65 across the quotient, 1 output register.
// The whole pipeline advances together; out_stall freezes it and raises in_stall
// only while the output register holds an untaken result.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
`include "vector3_arithmetic_unit_assert.svh"
module vector3_arithmetic_unit #(
	parameter int FRAC_BITS = v3au_pkg::FracBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire v3au_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output v3au_pkg::out_item_t out_data
);
	import v3au_pkg::*;
	localparam int SL = SqrtSteps + 1;
	localparam int DL = DivBits + 1;
	localparam int DEPTH = 2 + SL + DL + 1;

	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[DEPTH-1];

	// valid bits travel with data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	// stage 1: register inputs
	in_item_t in_s1;
	always_ff @(posedge clk) if (adv) in_s1 <= in_data;

	logic signed [31:0] a [3], b [3];
	assign a[0] = in_s1.ax; assign a[1] = in_s1.ay; assign a[2] = in_s1.az;
	assign b[0] = in_s1.bx; assign b[1] = in_s1.by_comp; assign b[2] = in_s1.bz;

	// stage 2: products
	logic signed [63:0] pab_s2 [3], pak_s2 [3], pc1_s2 [3], pc2_s2 [3];
	logic [63:0] sq_s2 [3];
	in_item_t in_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			in_s2 <= in_s1;
			for (int i = 0; i < 3; i++) begin
				pab_s2[i] <= a[i] * b[i];
				pak_s2[i] <= a[i] * in_s1.scalar_k;
				pc1_s2[i] <= a[(i+1)%3] * b[(i+2)%3];
				pc2_s2[i] <= b[(i+1)%3] * a[(i+2)%3];
				sq_s2[i] <= 64'(a[i] * a[i]);
			end
		end
	end

	// rounding of product sums, ties toward +inf
	function automatic logic signed [69:0] rnd(input logic signed [69:0] s);
		return (s + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] a2(input int i);
		case (i)
			0: return in_s2.ax;
			1: return in_s2.ay;
			default: return in_s2.az;
		endcase
	endfunction
	function automatic logic signed [31:0] b2(input int i);
		case (i)
			0: return in_s2.bx;
			1: return in_s2.by_comp;
			default: return in_s2.bz;
		endcase
	endfunction

	// stage 3: immediate results
	out_item_t fast_d;
	logic [32:0] t0;
	logic signed [69:0] w;
	always_comb begin
		fast_d = '0;
		t0 = '0;
		w = '0;
		for (int i = 0; i < 3; i++) begin
			case (in_s2.command)
				CMD_ADD: w = 70'(a2(i)) + 70'(b2(i));
				CMD_SUB: w = 70'(a2(i)) - 70'(b2(i));
				CMD_MUL: w = rnd(70'(pab_s2[i]));
				CMD_SCALE: w = rnd(70'(pak_s2[i]));
				CMD_CROSS: w = rnd(70'(pc1_s2[i]) - 70'(pc2_s2[i]));
				default: w = '0;
			endcase
			t0 = sat32(w);
			case (i)
				0: fast_d.rx = t0[31:0];
				1: fast_d.ry = t0[31:0];
				default: fast_d.rz = t0[31:0];
			endcase
			fast_d.overflow = fast_d.overflow | t0[32];
		end
		if (in_s2.command == CMD_DOT) begin
			t0 = sat32(rnd(70'(pab_s2[0]) + 70'(pab_s2[1]) + 70'(pab_s2[2])));
			fast_d.scalar_result = t0[31:0];
			fast_d.overflow = t0[32];
		end
	end

	// sum of squares into the square root
	logic [65:0] ssum;
	assign ssum = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
	logic [SqrtSteps:0] root;
	v3au_sqrt u_sqrt (.clk(clk), .adv(adv), .rad(ssum), .root(root));

	// delay line carrying the item across the root
	localparam int DW = $bits(in_item_t) + $bits(out_item_t);
	logic [DW-1:0] dl_q [SL];
	always_ff @(posedge clk) begin
		if (adv) begin
			dl_q[0] <= {in_s2, fast_d};
			for (int i = 1; i < SL; i++) dl_q[i] <= dl_q[i-1];
		end
	end
	in_item_t it_r;
	out_item_t fr_r;
	assign {it_r, fr_r} = dl_q[SL-1];

	// divisor select: |k| or root
	logic [63:0] den_c;
	logic zero_c;
	logic signed [31:0] k_r;
	assign k_r = it_r.scalar_k;
	always_comb begin
		if (it_r.command == CMD_DIV) begin
			den_c = 64'(k_r < 0 ? -33'(k_r) : 33'(k_r));
		end else begin
			den_c = 64'(root);
		end
		zero_c = (den_c == '0);
	end

	// per-lane divide; 2*|a|*2^F + den over 2*den
	logic [63:0] quo [3];
	logic [31:0] ac [3];
	assign ac[0] = it_r.ax; assign ac[1] = it_r.ay; assign ac[2] = it_r.az;
	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [32:0] mg;
		logic [63:0] nm;
		assign mg = ac[l][31] ? -{1'b1, ac[l]} : {1'b0, ac[l]};
		assign nm = (64'(mg) << (FRAC_BITS + 1)) + den_c;
		v3au_div u_div (.clk(clk), .adv(adv), .num(nm),
			.den(den_c << 1), .quo(quo[l]));
	end

	// side data across divider
	localparam int SW = $bits(in_item_t) + $bits(out_item_t) + 1 + SqrtSteps + 1;
	logic [SW-1:0] sd_q [DL];
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[0] <= {it_r, fr_r, zero_c, root};
			for (int i = 1; i < DL; i++) sd_q[i] <= sd_q[i-1];
		end
	end
	in_item_t it_e;
	out_item_t fr_e;
	logic zero_e;
	logic [SqrtSteps:0] root_e;
	assign {it_e, fr_e, zero_e, root_e} = sd_q[DL-1];

	// final select and saturation
	out_item_t res_c;
	logic [32:0] tq;
	logic signed [69:0] sq;
	logic [31:0] ae [3];
	assign ae[0] = it_e.ax; assign ae[1] = it_e.ay; assign ae[2] = it_e.az;
	always_comb begin
		res_c = fr_e;
		tq = '0;
		sq = '0;
		case (it_e.command)
			CMD_DIV, CMD_NORM: begin
				res_c = '0;
				res_c.divide_by_zero = zero_e;
				for (int i = 0; i < 3; i++) begin
					sq = 70'(quo[i]);
					if (ae[i][31] ^ (it_e.command == CMD_DIV && it_e.scalar_k[31])) sq = -sq;
					tq = sat32(sq);
					if (zero_e) begin
						if (it_e.command == CMD_NORM) tq = '0;
						else if (ae[i] == '0) tq = '0;
						else tq = ae[i][31] ? {1'b0, 32'h80000000} : {1'b0, 32'h7FFFFFFF};
					end
					case (i)
						0: res_c.rx = tq[31:0];
						1: res_c.ry = tq[31:0];
						default: res_c.rz = tq[31:0];
					endcase
					res_c.overflow = res_c.overflow | tq[32];
				end
			end
			CMD_MAG: begin
				res_c = '0;
				if (root_e > (SqrtSteps+1)'(32'h7FFFFFFF)) begin
					res_c.scalar_result = 32'h7FFFFFFF;
					res_c.overflow = 1'b1;
				end else begin
					res_c.scalar_result = root_e[31:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) if (adv) out_data <= res_c;

	`V3_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data),
		"result changed under stall")
	`V3_ASSERT_CLK(a_stall_src, in_stall |-> out_valid && out_stall, "stall without cause")
	`V3_ASSERT_CLK(a_flags, out_valid |-> !(out_data.overflow && out_data.divide_by_zero),
		"both flags set")
	`V3_ASSERT_RST(a_rst, out_valid, "valid out of reset")
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for vector3_arithmetic_unit: directed and random vector ops.
// Depends on v3au_pkg and the RTL of vector3_arithmetic_unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import v3au_pkg::*;

	localparam int FRAC = FracBitsDefault;
	localparam int LATENCY = 102;
	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [3:0] CMD_UNDEF_LO = 4'd9;
	localparam logic [3:0] CMD_UNDEF_HI = 4'd15;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE = 32'sh00010000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	logic in_fire;
	int gap_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	int accepted_count;
	int cycle_count;
	int error_count;

	vector3_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Clamp to 32 bits and flag saturation.
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
			inout logic ovf);
		if (v > 128'sh7FFFFFFF) begin
			ovf = 1'b1;
			return Q_MAX;
		end
		if (v < -128'sh80000000) begin
			ovf = 1'b1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	// Shift a product sum down by FRAC, ties toward +infinity.
	function automatic logic signed [127:0] round_prod(input logic signed [127:0] s);
		return (s + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// Quotient rounded half away from zero; den is positive.
	function automatic logic signed [127:0] div_away(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] mag;
		logic signed [127:0] q;
		mag = num < 0 ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return num < 0 ? -q : q;
	endfunction

	// Rounded square root of the sum of squares of a.
	function automatic logic [63:0] length_of(input logic signed [127:0] a[3]);
		logic [63:0] s;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		s = 0;
		for (int i = 0; i < 3; i++) s += 64'(a[i] * a[i]);
		x = s;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (128'(s) - 128'(r) * 128'(r) > 128'(r)) r++;
		return r;
	endfunction

	// Compute the expected result of one input transfer.
	function automatic out_item_t vector_result(input in_item_t it);
		out_item_t res;
		logic signed [127:0] a[3];
		logic signed [127:0] b[3];
		logic signed [127:0] k;
		logic signed [127:0] r[3];
		logic signed [127:0] sum;
		logic [63:0] m;
		logic ovf;
		logic dbz;
		int j;
		int n;
		a[0] = 128'(it.ax); a[1] = 128'(it.ay); a[2] = 128'(it.az);
		b[0] = 128'(it.bx); b[1] = 128'(it.by_comp); b[2] = 128'(it.bz);
		k = 128'(it.scalar_k);
		r[0] = 0; r[1] = 0; r[2] = 0;
		sum = 0;
		ovf = 1'b0;
		dbz = 1'b0;
		res = '0;
		case (it.command)
			CMD_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ovf);
			CMD_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ovf);
			CMD_MUL: for (int i = 0; i < 3; i++) r[i] = clamp32(round_prod(a[i] * b[i]), ovf);
			CMD_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32(round_prod(a[i] * k), ovf);
			CMD_DIV: begin
				if (k == 0) begin
					dbz = 1'b1;
					for (int i = 0; i < 3; i++)
						r[i] = a[i] > 0 ? 128'(Q_MAX) : (a[i] < 0 ? 128'(Q_MIN) : 0);
				end else begin
					for (int i = 0; i < 3; i++) begin
						sum = div_away(a[i] <<< FRAC, k < 0 ? -k : k);
						r[i] = clamp32(k < 0 ? -sum : sum, ovf);
					end
				end
			end
			CMD_DOT: begin
				for (int i = 0; i < 3; i++) sum += a[i] * b[i];
				res.scalar_result = clamp32(round_prod(sum), ovf);
			end
			CMD_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					j = (i + 1) % 3;
					n = (i + 2) % 3;
					r[i] = clamp32(round_prod(a[j] * b[n] - b[j] * a[n]), ovf);
				end
			end
			CMD_MAG: begin
				m = length_of(a);
				if (m > 64'h7FFFFFFF) begin
					ovf = 1'b1;
					res.scalar_result = Q_MAX;
				end else begin
					res.scalar_result = m[31:0];
				end
			end
			CMD_NORM: begin
				m = length_of(a);
				if (m == 0) dbz = 1'b1;
				else for (int i = 0; i < 3; i++)
					r[i] = clamp32(div_away(a[i] <<< FRAC, 128'(m)), ovf);
			end
			default: ;
		endcase
		res.rx = r[0][31:0];
		res.ry = r[1][31:0];
		res.rz = r[2][31:0];
		res.overflow = ovf;
		res.divide_by_zero = dbz;
		return res;
	endfunction

	// Pick a component value: full range, small, extreme or a whole multiple of one.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
			3: case ($urandom_range(0, 4))
				0: return 0;
				1: return Q_MAX;
				2: return Q_MIN;
				3: return -1;
				default: return 1;
			endcase
			4: return Q_ONE * ($signed($urandom_range(0, 64)) - 32);
			default: return $signed($urandom_range(0, 32'h2000000)) - 32'sh1000000;
		endcase
	endfunction

	function automatic in_item_t make_item(input logic [3:0] cmd,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az, input logic signed [31:0] bx,
			input logic signed [31:0] by_c, input logic signed [31:0] bz,
			input logic signed [31:0] k);
		in_item_t it;
		it.command = cmd;
		it.ax = ax; it.ay = ay; it.az = az;
		it.bx = bx; it.by_comp = by_c; it.bz = bz;
		it.scalar_k = k;
		return it;
	endfunction

	// Mostly no gap, some short ones, a few long ones, none during quiet stretches.
	function automatic int pick_delay(input int cyc);
		if ((cyc / 300) % 3 == 0) return 0;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom_range(1, 3);
			3: return $urandom_range(10, 40);
			default: return 0;
		endcase
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drive the input channel from the pending queue.
	always @(negedge clk) begin
		in_item_t nxt;
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				in_data <= nxt;
				in_valid <= 1'b1;
				gap_left <= pick_delay(cycle_count);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the output channel; once, hold off long enough to back up the pipeline.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && accepted_count >= 300) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= pick_delay(cycle_count + 150);
			out_stall <= 1'b0;
		end
	end

	// Record input transfers and check output transfers.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_results.push_back(vector_result(in_data));
				accepted_count <= accepted_count + 1;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.rx !== want.rx) begin
						$error("rx: expected %h got %h", want.rx, out_data.rx);
						error_count++;
					end
					if (out_data.ry !== want.ry) begin
						$error("ry: expected %h got %h", want.ry, out_data.ry);
						error_count++;
					end
					if (out_data.rz !== want.rz) begin
						$error("rz: expected %h got %h", want.rz, out_data.rz);
						error_count++;
					end
					if (out_data.scalar_result !== want.scalar_result) begin
						$error("scalar_result: expected %h got %h",
							want.scalar_result, out_data.scalar_result);
						error_count++;
					end
					if (out_data.overflow !== want.overflow) begin
						$error("overflow: expected %b got %b", want.overflow, out_data.overflow);
						error_count++;
					end
					if (out_data.divide_by_zero !== want.divide_by_zero) begin
						$error("divide_by_zero: expected %b got %b",
							want.divide_by_zero, out_data.divide_by_zero);
						error_count++;
					end
				end
			end
		end
	end

	// Count cycles and abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[vector3_arithmetic_unit] ERROR");
			$finish;
		end
	end

	// Build the stimulus, reset, then wait for the pipeline to drain.
	initial begin
		logic [3:0] cmd;
		in_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		in_fire = 1'b0;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		accepted_count = 0;
		cycle_count = 0;
		error_count = 0;

		// directed corners
		pending_items.push_back(make_item(CMD_ADD, Q_MAX, Q_MIN, 1, 1, -1, -1, 0));
		pending_items.push_back(make_item(CMD_SUB, Q_MIN, Q_MAX, 0, 1, -1, 0, 0));
		pending_items.push_back(make_item(CMD_MUL, 1, -1, Q_MAX, 32'sh8000, 32'sh8000,
			Q_MAX, 0));
		pending_items.push_back(make_item(CMD_MUL, Q_MIN, Q_MIN, Q_ONE, Q_MIN, Q_MAX,
			Q_ONE, 0));
		pending_items.push_back(make_item(CMD_SCALE, Q_MAX, Q_MIN, 3, 0, 0, 0, Q_MIN));
		pending_items.push_back(make_item(CMD_SCALE, Q_ONE, -Q_ONE, 7, 0, 0, 0, 32'sh8000));
		pending_items.push_back(make_item(CMD_DIV, 5, -5, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_DIV, Q_MAX, Q_MIN, 1, 0, 0, 0, 1));
		pending_items.push_back(make_item(CMD_DIV, Q_MIN, 3, -3, 0, 0, 0, -1));
		pending_items.push_back(make_item(CMD_DIV, 1, -1, 3, 0, 0, 0, 32'sh20000));
		pending_items.push_back(make_item(CMD_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MAX, 0));
		pending_items.push_back(make_item(CMD_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
			Q_MAX, 0));
		pending_items.push_back(make_item(CMD_DOT, 1, 1, 0, 32'sh8000, -32'sh8000, 0, 0));
		pending_items.push_back(make_item(CMD_CROSS, Q_ONE, 0, 0, 0, Q_ONE, 0, 0));
		pending_items.push_back(make_item(CMD_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
			Q_MIN, 0));
		pending_items.push_back(make_item(CMD_MAG, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_MAG, 3, 4, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_MAG, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_NORM, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_NORM, Q_MIN, Q_MAX, 1, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_NORM, 1, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_NORM, -3, 4, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(CMD_UNDEF_LO, Q_MAX, 1, 2, 3, 4, 5, 6));
		pending_items.push_back(make_item(CMD_UNDEF_HI, Q_MIN, -1, -2, -3, -4, -5, -6));

		// random items, mostly legal commands with zero divisors mixed in
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 19) == 0) cmd = 4'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
			else cmd = 4'($urandom_range(CMD_ADD, CMD_NORM));
			it = make_item(cmd, pick_value(), pick_value(), pick_value(), pick_value(),
				pick_value(), pick_value(), pick_value());
			if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) it.scalar_k = 0;
			if (cmd == CMD_NORM && $urandom_range(0, 7) == 0) begin
				it.ax = 0; it.ay = 0; it.az = 0;
			end
			pending_items.push_back(it);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (error_count == 0) begin
			$display("[vector3_arithmetic_unit] OK");
		end else begin
			$display("[vector3_arithmetic_unit] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
